// ===== rtl/sql_limit_offset_scanner_defines.svh =====
// assertion helpers used by sql_limit_offset_scanner.sv
`ifndef SQL_LIMIT_OFFSET_SCANNER_DEFINES_SVH
`define SQL_LIMIT_OFFSET_SCANNER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SQLO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SQLO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sqlo_pkg.sv =====
`default_nettype none
package sqlo_pkg;

  localparam int unsigned ValW = 32;
  localparam logic [ValW-1:0] SatMax = '1;

  // scanner phases
  typedef enum logic [3:0] {
    PH_NORMAL     = 4'd0,
    PH_QUOTE      = 4'd1,
    PH_ESCAPE     = 4'd2,
    PH_KW_END     = 4'd3,
    PH_WS_LIMIT   = 4'd4,
    PH_LIMIT_DIG  = 4'd5,
    PH_WS_AFTER   = 4'd6,
    PH_OFF_KW     = 4'd7,
    PH_OFF_END    = 4'd8,
    PH_WS_OFFSET  = 4'd9,
    PH_OFF_DIG    = 4'd10,
    PH_DONE_FOUND = 4'd11,
    PH_DONE_NONE  = 4'd12
  } phase_t;

  // one result beat from the scan core
  typedef struct packed {
    logic            found;
    logic [ValW-1:0] limit;
    logic [ValW-1:0] offset;
  } result_t;

  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChLowerL = 8'h6c;
  localparam logic [7:0] ChLowerO = 8'h6f;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5a)) ? (b + 8'h20) : b;
  endfunction

  // letters of "limit" by matched count
  function automatic logic [7:0] kw_limit_ch(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h6c;
      3'd1: c = 8'h69;
      3'd2: c = 8'h6d;
      3'd3: c = 8'h69;
      3'd4: c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // letters of "offset" by matched count
  function automatic logic [7:0] kw_offset_ch(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h6f;
      3'd1: c = 8'h66;
      3'd2: c = 8'h66;
      3'd3: c = 8'h73;
      3'd4: c = 8'h65;
      3'd5: c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // acc * 10 + digit, saturating; times ten as two shifts and an add
  function automatic logic [ValW-1:0] acc_digit(input logic [ValW-1:0] acc,
                                                input logic [7:0] b);
    logic [ValW+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{ValW{1'b0}}, b[3:0]};
    return (v[ValW+3:ValW] != 4'b0) ? SatMax : v[ValW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sql_limit_offset_scanner.sv =====
// Scans a query one byte per beat and reports the first LIMIT clause outside
// quoted strings, with its limit and optional OFFSET value (both saturating at
// 2^32-1). One byte is taken every cycle, except that a final byte waits in the
// input register while an earlier result is still not taken. The scan state
// steps once per byte through a single registered stage, and a result beat is
// registered as the final byte leaves the input register. Only the final byte
// yields a result; the scanner then starts afresh for the next query.
`default_nettype none
`include "sql_limit_offset_scanner_defines.svh"
module sql_limit_offset_scanner import sqlo_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_text_byte,
  input  wire logic            in_is_final,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_clause_found,
  output logic [ValW-1:0]      out_limit_value,
  output logic [ValW-1:0]      out_offset_value
);

  logic       stage_v_r;
  logic [7:0] byte_r;
  logic       final_r;
  logic       out_valid_r;
  result_t    out_r;
  result_t    core_res;
  logic       out_free;
  logic       advance;

  // stage handshake
  assign out_free = !out_valid_r || out_ready;
  assign advance  = stage_v_r && (!final_r || out_free);
  assign in_ready = !stage_v_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ready) begin
      stage_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r  <= in_text_byte;
      final_r <= in_is_final;
    end
  end

  sqlo_scan_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .text_byte (byte_r),
    .is_final  (final_r),
    .result    (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && final_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && final_r) out_r <= core_res;
  end

  assign out_valid        = out_valid_r;
  assign out_clause_found = out_r.found;
  assign out_limit_value  = out_r.limit;
  assign out_offset_value = out_r.offset;

  // checks
  `SQLO_ASSERT_IMP(a_none_is_zero, out_valid_r && !out_r.found,
    (out_r.limit == '0) && (out_r.offset == '0), "not-found beat carries values")
  `SQLO_ASSERT_NXT(a_final_held, stage_v_r && final_r && !out_free,
    stage_v_r && final_r, "final byte dropped while result blocked")
  `SQLO_ASSERT_NXT(a_final_emits, advance && final_r,
    out_valid_r, "final byte gave no result beat")

endmodule
`default_nettype wire

// ===== rtl/sqlo_scan_core.sv =====
`default_nettype none
module sqlo_scan_core import sqlo_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] text_byte,
  input  wire logic       is_final,
  output result_t         result
);

  phase_t          ph_r, ph_nxt;
  logic [2:0]      kp_r, kp_nxt;
  logic            qd_r, qd_nxt;
  logic            pa_r, pa_nxt;
  logic [ValW-1:0] lim_r, lim_nxt;
  logic [ValW-1:0] off_r, off_nxt;
  logic [7:0]      lc;
  logic            found;

  assign lc = to_lower(text_byte);

  // next scan state for this byte
  always_comb begin
    ph_nxt  = ph_r;
    kp_nxt  = kp_r;
    qd_nxt  = qd_r;
    pa_nxt  = pa_r;
    lim_nxt = lim_r;
    off_nxt = off_r;
    if ((ph_r == PH_DONE_FOUND) || (ph_r == PH_DONE_NONE)) begin
      ph_nxt = ph_r;
    end else if (text_byte == 8'h00) begin
      ph_nxt = (ph_r >= PH_LIMIT_DIG) ? PH_DONE_FOUND : PH_DONE_NONE;
    end else begin
      case (ph_r)
        PH_NORMAL: begin
          if ((kp_r != 3'd0) && (kp_r < 3'd5) && (lc == kw_limit_ch(kp_r))) begin
            kp_nxt = kp_r + 3'd1;
            pa_nxt = 1'b1;
            if (kp_r == 3'd4) begin
              ph_nxt = PH_KW_END;
              kp_nxt = 3'd0;
            end
          end else begin
            // fresh byte, no partial keyword
            kp_nxt = 3'd0;
            if ((text_byte == ChSquote) || (text_byte == ChDquote)) begin
              ph_nxt = PH_QUOTE;
              qd_nxt = (text_byte == ChDquote);
              pa_nxt = 1'b0;
            end else begin
              if ((lc == ChLowerL) && !pa_r) kp_nxt = 3'd1;
              pa_nxt = is_alnum(text_byte);
            end
          end
        end
        PH_QUOTE: begin
          if (text_byte == ChBslash) begin
            ph_nxt = PH_ESCAPE;
          end else if (text_byte == (qd_r ? ChDquote : ChSquote)) begin
            ph_nxt = PH_NORMAL;
            kp_nxt = 3'd0;
            pa_nxt = 1'b0;
          end
        end
        PH_ESCAPE: ph_nxt = PH_QUOTE;
        PH_KW_END, PH_WS_LIMIT: begin
          if ((ph_r == PH_KW_END) && is_alnum(text_byte)) begin
            ph_nxt = PH_NORMAL;
            kp_nxt = 3'd0;
            pa_nxt = 1'b1;
          end else if (is_space(text_byte)) begin
            ph_nxt = PH_WS_LIMIT;
          end else if (is_digit(text_byte)) begin
            ph_nxt  = PH_LIMIT_DIG;
            lim_nxt = {{(ValW-4){1'b0}}, text_byte[3:0]};
          end else begin
            // byte not checked for a quote or a keyword start
            ph_nxt = PH_NORMAL;
            kp_nxt = 3'd0;
            pa_nxt = is_alnum(text_byte);
          end
        end
        PH_LIMIT_DIG, PH_WS_AFTER: begin
          if ((ph_r == PH_LIMIT_DIG) && is_digit(text_byte)) begin
            lim_nxt = acc_digit(lim_r, text_byte);
          end else if (is_space(text_byte)) begin
            ph_nxt = PH_WS_AFTER;
          end else if (lc == ChLowerO) begin
            ph_nxt = PH_OFF_KW;
            kp_nxt = 3'd1;
          end else begin
            ph_nxt = PH_DONE_FOUND;
          end
        end
        PH_OFF_KW: begin
          if ((kp_r < 3'd6) && (lc == kw_offset_ch(kp_r))) begin
            kp_nxt = kp_r + 3'd1;
            if (kp_r == 3'd5) begin
              ph_nxt = PH_OFF_END;
              kp_nxt = 3'd0;
            end
          end else begin
            ph_nxt = PH_DONE_FOUND;
          end
        end
        PH_OFF_END: ph_nxt = is_space(text_byte) ? PH_WS_OFFSET : PH_DONE_FOUND;
        PH_WS_OFFSET: begin
          if (is_digit(text_byte)) begin
            ph_nxt  = PH_OFF_DIG;
            off_nxt = {{(ValW-4){1'b0}}, text_byte[3:0]};
          end else if (!is_space(text_byte)) begin
            ph_nxt = PH_DONE_FOUND;
          end
        end
        PH_OFF_DIG: begin
          if (is_digit(text_byte)) off_nxt = acc_digit(off_r, text_byte);
          else ph_nxt = PH_DONE_FOUND;
        end
        default: ph_nxt = PH_DONE_NONE;
      endcase
    end
  end

  // result as seen after this byte
  assign found         = (ph_nxt >= PH_LIMIT_DIG) && (ph_nxt <= PH_DONE_FOUND);
  assign result.found  = found;
  assign result.limit  = found ? lim_nxt : '0;
  assign result.offset = found ? off_nxt : '0;

  // state register, back to start after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && is_final)) begin
      ph_r  <= PH_NORMAL;
      kp_r  <= 3'd0;
      qd_r  <= 1'b0;
      pa_r  <= 1'b0;
      lim_r <= '0;
      off_r <= '0;
    end else if (step) begin
      ph_r  <= ph_nxt;
      kp_r  <= kp_nxt;
      qd_r  <= qd_nxt;
      pa_r  <= pa_nxt;
      lim_r <= lim_nxt;
      off_r <= off_nxt;
    end
  end

endmodule
`default_nettype wire
